/* src/value_noise_2d_octaves_core_assert.svh */
// Assertion helpers for the value noise core.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef VALUE_NOISE_2D_OCTAVES_CORE_ASSERT_SVH
`define VALUE_NOISE_2D_OCTAVES_CORE_ASSERT_SVH

// Same-cycle implication, checked outside of reset.
`define VN_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("value noise core: same-cycle check failed");

// Next-cycle implication, checked outside of reset.
`define VN_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("value noise core: next-cycle check failed");

`endif

/* src/vnoise_pkg.sv */
`timescale 1ns / 1ps
package vnoise_pkg;

  localparam int COORD_BITS  = 12;
  localparam int MAX_OCTAVES = 8;
  localparam int PRIME_ROWS  = 10;
  localparam int FRAC_BITS   = 16;
  localparam int STORED_ROWS = 10;

  localparam int Q16_BITS   = 16;
  localparam int ONE_Q16    = 65536;
  localparam int PERS_W     = 17;
  localparam int OCT_W      = 4;
  localparam int OFS_W      = 4;
  localparam int ROW_W      = $clog2(STORED_ROWS);
  localparam int ROW_SUM_W  = 5;
  localparam int ROW_FOLDS  = (2**ROW_SUM_W - 1) / PRIME_ROWS;
  localparam int VAL_W      = FRAC_BITS + 2;
  localparam int ACC_W      = VAL_W + 5;
  localparam int OUT_W      = FRAC_BITS + 5;
  localparam int TOTAL_W    = OUT_W + 1;
  localparam int SAT_LIM    = 2**(FRAC_BITS + 3);
  localparam int LAT_SH     = 30 - FRAC_BITS;
  localparam int HASH_YMUL  = 57;
  localparam int HASH_SHL   = 13;
  localparam int POLY_Q     = 30;
  localparam int F_SH       = 2*POLY_Q - Q16_BITS;
  localparam int MUL_W      = 33;
  localparam int PROD_W     = 2*MUL_W;
  localparam int APB_AW     = 4;
  localparam int APB_DW     = 32;

  localparam logic [PERS_W-1:0] RST_PERSISTENCE  = PERS_W'(32768);
  localparam logic [OCT_W-1:0]  RST_OCTAVE_COUNT = OCT_W'(4);
  localparam logic [OFS_W-1:0]  RST_TABLE_OFFSET = OFS_W'(0);

  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] POLY_SQ    = 3'd0;
  localparam logic [STEP_W-1:0] POLY_SIN   = 3'd5;
  localparam logic [STEP_W-1:0] POLY_LAST  = 3'd6;
  localparam logic [STEP_W-1:0] BLEND_ROW0 = 3'd0;
  localparam logic [STEP_W-1:0] BLEND_ROW1 = 3'd1;
  localparam logic [STEP_W-1:0] BLEND_LAST = 3'd2;

  localparam int PT_W  = 2;
  localparam int NBR_W = 4;
  localparam logic [PT_W-1:0]  PT_LAST  = 2'd3;
  localparam logic [NBR_W-1:0] NBR_LAST = 4'd8;

  localparam logic [31:0] POLY_C1 = 32'd1686629713;
  localparam logic [31:0] POLY_C3 = 32'd693598671;
  localparam logic [31:0] POLY_C5 = 32'd85569306;
  localparam logic [31:0] POLY_C7 = 32'd5026998;
  localparam logic [31:0] POLY_C9 = 32'd172272;

  localparam logic [31:0] PRIME_A [STORED_ROWS] = '{
    32'd995615039, 32'd831731269, 32'd174329291, 32'd362489573, 32'd457025711,
    32'd787070341, 32'd405493717, 32'd458904767, 32'd531736441, 32'd997169939};
  localparam logic [31:0] PRIME_B [STORED_ROWS] = '{
    32'd600173719, 32'd162318869, 32'd946737083, 32'd795918041, 32'd880830799,
    32'd177340217, 32'd291031019, 32'd676625681, 32'd939683957, 32'd842027887};
  localparam logic [31:0] PRIME_C [STORED_ROWS] = '{
    32'd701464987, 32'd136250887, 32'd245679977, 32'd350777237, 32'd909678923,
    32'd593320781, 32'd391950901, 32'd424452397, 32'd810651871, 32'd423882827};

  typedef struct packed {
    logic [PERS_W-1:0] persistence;
    logic [OCT_W-1:0]  octave_count;
    logic [OFS_W-1:0]  table_offset;
  } cfg_t;

  typedef enum logic [1:0] {
    REG_PERSISTENCE,
    REG_OCTAVE_COUNT,
    REG_TABLE_OFFSET
  } reg_idx_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SETUP,
    OP_POLY,
    OP_HASH,
    OP_BLEND,
    OP_AMP,
    OP_CONTRIB,
    OP_FINISH
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SETUP,
    S_POLY,
    S_HASH,
    S_DRAIN,
    S_BLEND,
    S_AMP,
    S_CONTRIB,
    S_FINISH
  } state_t;

  typedef struct packed {
    op_t               op;
    logic [OCT_W-1:0]  octave;
    logic [OCT_W-1:0]  shift;
    logic              poly_y;
    logic [STEP_W-1:0] step;
    logic [PT_W-1:0]   pt;
    logic [NBR_W-1:0]  nbr;
  } cmd_t;

  typedef struct packed {
    logic hash_busy;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic        valid;
    logic [PT_W-1:0] pt;
    logic [1:0]  wsh;
    logic        last;
  } hash_tag_t;

  typedef struct packed {
    logic signed [1:0] dx;
    logic signed [1:0] dy;
    logic [1:0]        wsh;
  } nbr_t;

  // Neighbor offsets of the 3x3 smoothing window; weight is 1 << wsh.
  function automatic nbr_t nbr_of(input logic [NBR_W-1:0] m);
    nbr_t r;
    unique case (m)
      4'd0:    r = '{dx: -2'sd1, dy: -2'sd1, wsh: 2'd0};
      4'd1:    r = '{dx:  2'sd0, dy: -2'sd1, wsh: 2'd1};
      4'd2:    r = '{dx:  2'sd1, dy: -2'sd1, wsh: 2'd0};
      4'd3:    r = '{dx: -2'sd1, dy:  2'sd0, wsh: 2'd1};
      4'd4:    r = '{dx:  2'sd0, dy:  2'sd0, wsh: 2'd2};
      4'd5:    r = '{dx:  2'sd1, dy:  2'sd0, wsh: 2'd1};
      4'd6:    r = '{dx: -2'sd1, dy:  2'sd1, wsh: 2'd0};
      4'd7:    r = '{dx:  2'sd0, dy:  2'sd1, wsh: 2'd1};
      4'd8:    r = '{dx:  2'sd1, dy:  2'sd1, wsh: 2'd0};
      default: r = '{dx:  2'sd0, dy:  2'sd0, wsh: 2'd0};
    endcase
    return r;
  endfunction

  // Horner coefficient used by each polynomial step.
  function automatic logic [31:0] horner_c(input logic [STEP_W-1:0] step);
    logic [31:0] c;
    unique case (step)
      3'd1:    c = POLY_C7;
      3'd2:    c = POLY_C5;
      3'd3:    c = POLY_C3;
      3'd4:    c = POLY_C1;
      default: c = POLY_C9;
    endcase
    return c;
  endfunction

endpackage

/* src/vnoise_cfg.sv */
`timescale 1ns / 1ps
module vnoise_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [vnoise_pkg::APB_AW-1:0]      paddr,
  input  logic [vnoise_pkg::APB_DW-1:0]      pwdata,
  output logic [vnoise_pkg::APB_DW-1:0]      prdata,
  output logic                               pready,
  output vnoise_pkg::cfg_t                   cfg_o
);

  localparam int DW = vnoise_pkg::APB_DW;
  localparam int AW = vnoise_pkg::APB_AW;

  vnoise_pkg::cfg_t     cfg_r, cfg_nxt;
  vnoise_pkg::reg_idx_t idx;
  logic                 wr_en;

  assign pready = 1'b1;
  assign cfg_o  = cfg_r;
  assign idx    = vnoise_pkg::reg_idx_t'(paddr[AW-1:2]);
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        vnoise_pkg::REG_PERSISTENCE:
          cfg_nxt.persistence = pwdata[vnoise_pkg::PERS_W-1:0];
        vnoise_pkg::REG_OCTAVE_COUNT:
          cfg_nxt.octave_count = pwdata[vnoise_pkg::OCT_W-1:0];
        vnoise_pkg::REG_TABLE_OFFSET:
          cfg_nxt.table_offset = pwdata[vnoise_pkg::OFS_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      vnoise_pkg::REG_PERSISTENCE:  prdata = DW'(cfg_r.persistence);
      vnoise_pkg::REG_OCTAVE_COUNT: prdata = DW'(cfg_r.octave_count);
      vnoise_pkg::REG_TABLE_OFFSET: prdata = DW'(cfg_r.table_offset);
      default:                      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.persistence  <= vnoise_pkg::RST_PERSISTENCE;
      cfg_r.octave_count <= vnoise_pkg::RST_OCTAVE_COUNT;
      cfg_r.table_offset <= vnoise_pkg::RST_TABLE_OFFSET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* src/vnoise_dp.sv */
`timescale 1ns / 1ps
module vnoise_dp (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  vnoise_pkg::cfg_t                         cfg_i,
  input  vnoise_pkg::cmd_t                         cmd_i,
  output vnoise_pkg::status_t                      st_o,
  input  logic [vnoise_pkg::COORD_BITS-1:0]        in_x_coord,
  input  logic [vnoise_pkg::COORD_BITS-1:0]        in_y_coord,
  input  logic                                     out_ready,
  output logic                                     out_valid,
  output logic signed [vnoise_pkg::OUT_W-1:0]      out_noise_value
);

  localparam int CB    = vnoise_pkg::COORD_BITS;
  localparam int QB    = vnoise_pkg::Q16_BITS;
  localparam int PW    = vnoise_pkg::PERS_W;
  localparam int VW    = vnoise_pkg::VAL_W;
  localparam int AW    = vnoise_pkg::ACC_W;
  localparam int TW    = vnoise_pkg::TOTAL_W;
  localparam int OW    = vnoise_pkg::OUT_W;
  localparam int MW    = vnoise_pkg::MUL_W;
  localparam int PRW   = vnoise_pkg::PROD_W;
  localparam int PQ    = vnoise_pkg::POLY_Q;
  localparam int RW    = vnoise_pkg::ROW_W;
  localparam int RSW   = vnoise_pkg::ROW_SUM_W;
  localparam int BSW   = VW + QB + 4;
  localparam logic [PW-1:0] ONE = PW'(vnoise_pkg::ONE_Q16);
  localparam logic signed [TW-1:0] LIM_P = TW'(vnoise_pkg::SAT_LIM);
  localparam logic signed [TW-1:0] LIM_N = -LIM_P;

  // Prime row for an octave: (offset + k) folded into the stored rows.
  function automatic logic [RW-1:0] row_of(input logic [RSW-1:0] sum);
    logic [RSW-1:0] r;
    r = sum;
    for (int i = 0; i < vnoise_pkg::ROW_FOLDS; i++) begin
      if (r >= RSW'(vnoise_pkg::PRIME_ROWS)) r = r - RSW'(vnoise_pkg::PRIME_ROWS);
    end
    if (r >= RSW'(vnoise_pkg::STORED_ROWS)) r = r - RSW'(vnoise_pkg::STORED_ROWS);
    return r[RW-1:0];
  endfunction

  logic [CB-1:0]       x_r, x_nxt, y_r, y_nxt, ix_r, ix_nxt, iy_r, iy_nxt;
  logic [QB-1:0]       tx_r, tx_nxt, ty_r, ty_nxt;
  logic [31:0]         ra_r, ra_nxt, rb_r, rb_nxt, rc_r, rc_nxt;
  logic [PW-1:0]       p_r, p_nxt, amp_r, amp_nxt, fx_r, fx_nxt, fy_r, fy_nxt;
  logic [31:0]         w_r, w_nxt, hp_r, hp_nxt, s_r, s_nxt;
  logic [31:0]         h0_r, h0_nxt, sq_r, sq_nxt, mh_r, mh_nxt;
  logic [31:0]         hn1_r, hn1_nxt, hn2_r, hn2_nxt;
  logic [30:0]         t_r, t_nxt;
  vnoise_pkg::hash_tag_t tag_r [4];
  vnoise_pkg::hash_tag_t tag_nxt [4];
  logic signed [AW-1:0] acc_r, acc_nxt;
  logic signed [VW-1:0] sv_r [4];
  logic signed [VW-1:0] sv_nxt [4];
  logic signed [VW-1:0] i1_r, i1_nxt, i2_r, i2_nxt, vb_r, vb_nxt;
  logic signed [TW-1:0] total_r, total_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic signed [OW-1:0] out_value_r, out_value_nxt;

  // Shared arithmetic unit operands.
  logic signed [MW-1:0]  ma, mb;
  logic signed [PRW-1:0] prod;
  logic [PRW-1:0]        pu, pshift, pf;
  logic [QB-1:0]         tsel;
  logic [PQ-1:0]         u;
  logic signed [VW-1:0]  ba, bb;
  logic signed [VW:0]    bd;
  logic [PW-1:0]         fsel;
  logic signed [BSW-1:0] bsum;

  // Hash issue and accumulate signals.
  vnoise_pkg::nbr_t     nb;
  logic [31:0]          cx, cy, n0, n1;
  logic signed [VW-1:0] lat;
  logic signed [AW-1:0] wl, asum;
  logic [CB+QB-1:0]     xw, yw;
  logic signed [TW-1:0] sat;

  assign prod   = ma * mb;
  assign pu     = prod;
  assign pshift = pu >> PQ;
  assign pf     = pu >> vnoise_pkg::F_SH;
  assign tsel   = cmd_i.poly_y ? ty_r : tx_r;
  assign u      = {tsel, {(PQ-QB){1'b0}}};
  assign bd     = (VW+1)'(bb) - (VW+1)'(ba);
  assign bsum   = (BSW'(ba) <<< QB) + BSW'(prod);

  // Operand selection for the shared multiplier.
  always_comb begin
    ba   = '0;
    bb   = '0;
    fsel = fx_r;
    unique case (cmd_i.step)
      vnoise_pkg::BLEND_ROW0: begin ba = sv_r[0]; bb = sv_r[1]; fsel = fx_r; end
      vnoise_pkg::BLEND_ROW1: begin ba = sv_r[2]; bb = sv_r[3]; fsel = fx_r; end
      default:                begin ba = i1_r;    bb = i2_r;    fsel = fy_r; end
    endcase
  end

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd_i.op)
      vnoise_pkg::OP_POLY: begin
        if (cmd_i.step == vnoise_pkg::POLY_SQ) begin
          ma = MW'(u);
          mb = MW'(u);
        end else if (cmd_i.step == vnoise_pkg::POLY_SIN) begin
          ma = MW'(u);
          mb = MW'(hp_r);
        end else if (cmd_i.step == vnoise_pkg::POLY_LAST) begin
          ma = MW'(s_r);
          mb = MW'(s_r);
        end else begin
          ma = MW'(w_r);
          mb = MW'(hp_r);
        end
      end
      vnoise_pkg::OP_BLEND: begin
        ma = MW'(bd);
        mb = MW'(fsel);
      end
      vnoise_pkg::OP_AMP: begin
        ma = MW'(amp_r);
        mb = MW'(p_r);
      end
      vnoise_pkg::OP_CONTRIB: begin
        ma = MW'(vb_r);
        mb = MW'(amp_r);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  // Lattice coordinates of the issued hash and its first mixing step.
  always_comb begin
    nb = vnoise_pkg::nbr_of(cmd_i.nbr);
    cx = 32'(ix_r) + 32'(cmd_i.pt[0]) + {{30{nb.dx[1]}}, nb.dx};
    cy = 32'(iy_r) + 32'(cmd_i.pt[1]) + {{30{nb.dy[1]}}, nb.dy};
    n0 = cx + cy * 32'(vnoise_pkg::HASH_YMUL);
    n1 = (n0 << vnoise_pkg::HASH_SHL) ^ n0;
  end

  // Lattice value leaving the hash pipe and its smoothing weight.
  always_comb begin
    lat  = VW'(ONE) - VW'(t_r[30:vnoise_pkg::LAT_SH]);
    wl   = AW'(lat) <<< tag_r[3].wsh;
    asum = acc_r + wl;
    xw   = {x_r, {QB{1'b0}}} >> cmd_i.shift;
    yw   = {y_r, {QB{1'b0}}} >> cmd_i.shift;
    if (total_r > LIM_P) sat = LIM_P;
    else if (total_r < LIM_N) sat = LIM_N;
    else sat = total_r;
  end

  always_comb begin
    x_nxt = x_r;   y_nxt = y_r;   ix_nxt = ix_r; iy_nxt = iy_r;
    tx_nxt = tx_r; ty_nxt = ty_r;
    ra_nxt = ra_r; rb_nxt = rb_r; rc_nxt = rc_r;
    p_nxt = p_r;   amp_nxt = amp_r; fx_nxt = fx_r; fy_nxt = fy_r;
    w_nxt = w_r;   hp_nxt = hp_r; s_nxt = s_r;
    i1_nxt = i1_r; i2_nxt = i2_r; vb_nxt = vb_r;
    total_nxt = total_r;
    out_value_nxt = out_value_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    acc_nxt = acc_r;
    for (int i = 0; i < 4; i++) sv_nxt[i] = sv_r[i];

    // Hash pipe: one lattice point enters per cycle.
    h0_nxt  = n1;
    sq_nxt  = h0_r * h0_r;
    hn1_nxt = h0_r;
    mh_nxt  = sq_r * ra_r + rb_r;
    hn2_nxt = hn1_r;
    t_nxt   = 31'(hn2_r * mh_r + rc_r);
    tag_nxt[0].valid = (cmd_i.op == vnoise_pkg::OP_HASH);
    tag_nxt[0].pt    = cmd_i.pt;
    tag_nxt[0].wsh   = nb.wsh;
    tag_nxt[0].last  = (cmd_i.nbr == vnoise_pkg::NBR_LAST);
    for (int i = 1; i < 4; i++) tag_nxt[i] = tag_r[i-1];

    if (tag_r[3].valid) begin
      if (tag_r[3].last) begin
        sv_nxt[tag_r[3].pt] = asum[VW+3:4];
        acc_nxt = '0;
      end else begin
        acc_nxt = asum;
      end
    end

    unique case (cmd_i.op)
      vnoise_pkg::OP_LOAD: begin
        x_nxt     = in_x_coord;
        y_nxt     = in_y_coord;
        total_nxt = '0;
        amp_nxt   = ONE;
        p_nxt     = (cfg_i.persistence > ONE) ? ONE : cfg_i.persistence;
        acc_nxt   = '0;
      end
      vnoise_pkg::OP_SETUP: begin
        ix_nxt = x_r >> cmd_i.shift;
        iy_nxt = y_r >> cmd_i.shift;
        tx_nxt = xw[QB-1:0];
        ty_nxt = yw[QB-1:0];
        ra_nxt = vnoise_pkg::PRIME_A[row_of(RSW'(cfg_i.table_offset) + RSW'(cmd_i.octave))];
        rb_nxt = vnoise_pkg::PRIME_B[row_of(RSW'(cfg_i.table_offset) + RSW'(cmd_i.octave))];
        rc_nxt = vnoise_pkg::PRIME_C[row_of(RSW'(cfg_i.table_offset) + RSW'(cmd_i.octave))];
      end
      vnoise_pkg::OP_POLY: begin
        if (cmd_i.step == vnoise_pkg::POLY_SQ) begin
          w_nxt  = pshift[31:0];
          hp_nxt = vnoise_pkg::POLY_C9;
        end else if (cmd_i.step == vnoise_pkg::POLY_SIN) begin
          s_nxt = pshift[31:0];
        end else if (cmd_i.step == vnoise_pkg::POLY_LAST) begin
          if (cmd_i.poly_y) fy_nxt = (pf > PRW'(ONE)) ? ONE : pf[PW-1:0];
          else              fx_nxt = (pf > PRW'(ONE)) ? ONE : pf[PW-1:0];
        end else begin
          hp_nxt = vnoise_pkg::horner_c(cmd_i.step) - pshift[31:0];
        end
      end
      vnoise_pkg::OP_BLEND: begin
        if (cmd_i.step == vnoise_pkg::BLEND_ROW0) i1_nxt = bsum[QB +: VW];
        else if (cmd_i.step == vnoise_pkg::BLEND_ROW1) i2_nxt = bsum[QB +: VW];
        else vb_nxt = bsum[QB +: VW];
      end
      vnoise_pkg::OP_AMP: amp_nxt = pu[QB +: PW];
      vnoise_pkg::OP_CONTRIB: total_nxt = total_r + TW'(prod >>> QB);
      vnoise_pkg::OP_FINISH: begin
        out_valid_nxt = 1'b1;
        out_value_nxt = sat[OW-1:0];
      end
      default: total_nxt = total_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int i = 0; i < 4; i++) tag_r[i] <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < 4; i++) tag_r[i] <= tag_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;   y_r <= y_nxt;   ix_r <= ix_nxt; iy_r <= iy_nxt;
    tx_r <= tx_nxt; ty_r <= ty_nxt;
    ra_r <= ra_nxt; rb_r <= rb_nxt; rc_r <= rc_nxt;
    p_r <= p_nxt;   amp_r <= amp_nxt; fx_r <= fx_nxt; fy_r <= fy_nxt;
    w_r <= w_nxt;   hp_r <= hp_nxt; s_r <= s_nxt;
    h0_r <= h0_nxt; sq_r <= sq_nxt; mh_r <= mh_nxt;
    hn1_r <= hn1_nxt; hn2_r <= hn2_nxt; t_r <= t_nxt;
    acc_r <= acc_nxt;
    for (int i = 0; i < 4; i++) sv_r[i] <= sv_nxt[i];
    i1_r <= i1_nxt; i2_r <= i2_nxt; vb_r <= vb_nxt;
    total_r <= total_nxt;
    out_value_r <= out_value_nxt;
  end

  assign st_o.hash_busy = tag_r[0].valid | tag_r[1].valid | tag_r[2].valid | tag_r[3].valid;
  assign st_o.out_free  = ~out_valid_r | out_ready;
  assign out_valid       = out_valid_r;
  assign out_noise_value = out_value_r;

endmodule

/* src/vnoise_ctrl.sv */
`timescale 1ns / 1ps
`include "value_noise_2d_octaves_core_assert.svh"
module vnoise_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  vnoise_pkg::cfg_t    cfg_i,
  input  logic                in_valid,
  output logic                in_ready,
  input  vnoise_pkg::status_t st_i,
  output vnoise_pkg::cmd_t    cmd_o
);

  localparam int OW = vnoise_pkg::OCT_W;

  vnoise_pkg::state_t state_r, state_nxt;
  logic [OW-1:0]                 k_r, k_nxt;
  logic [vnoise_pkg::STEP_W-1:0] step_r, step_nxt;
  logic                          poly_y_r, poly_y_nxt;
  logic [vnoise_pkg::PT_W-1:0]   pt_r, pt_nxt;
  logic [vnoise_pkg::NBR_W-1:0]  nbr_r, nbr_nxt;
  logic [OW-1:0]                 oc;

  assign oc = (cfg_i.octave_count > OW'(vnoise_pkg::MAX_OCTAVES)) ?
              OW'(vnoise_pkg::MAX_OCTAVES) : cfg_i.octave_count;

  always_comb begin
    state_nxt  = state_r;
    k_nxt      = k_r;
    step_nxt   = step_r;
    poly_y_nxt = poly_y_r;
    pt_nxt     = pt_r;
    nbr_nxt    = nbr_r;
    in_ready   = 1'b0;
    cmd_o.op     = vnoise_pkg::OP_NONE;
    cmd_o.octave = k_r;
    cmd_o.shift  = oc - OW'(1) - k_r;
    cmd_o.poly_y = poly_y_r;
    cmd_o.step   = step_r;
    cmd_o.pt     = pt_r;
    cmd_o.nbr    = nbr_r;
    unique case (state_r)
      vnoise_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_o.op  = vnoise_pkg::OP_LOAD;
          k_nxt     = '0;
          state_nxt = (oc == '0) ? vnoise_pkg::S_FINISH : vnoise_pkg::S_SETUP;
        end
      end
      vnoise_pkg::S_SETUP: begin
        cmd_o.op   = vnoise_pkg::OP_SETUP;
        step_nxt   = '0;
        poly_y_nxt = 1'b0;
        state_nxt  = vnoise_pkg::S_POLY;
      end
      vnoise_pkg::S_POLY: begin
        cmd_o.op = vnoise_pkg::OP_POLY;
        if (step_r == vnoise_pkg::POLY_LAST) begin
          step_nxt = '0;
          if (poly_y_r) begin
            pt_nxt    = '0;
            nbr_nxt   = '0;
            state_nxt = vnoise_pkg::S_HASH;
          end else begin
            poly_y_nxt = 1'b1;
          end
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      vnoise_pkg::S_HASH: begin
        cmd_o.op = vnoise_pkg::OP_HASH;
        if (nbr_r == vnoise_pkg::NBR_LAST) begin
          nbr_nxt = '0;
          if (pt_r == vnoise_pkg::PT_LAST) state_nxt = vnoise_pkg::S_DRAIN;
          else pt_nxt = pt_r + 1'b1;
        end else begin
          nbr_nxt = nbr_r + 1'b1;
        end
      end
      vnoise_pkg::S_DRAIN: begin
        if (!st_i.hash_busy) begin
          step_nxt  = '0;
          state_nxt = vnoise_pkg::S_BLEND;
        end
      end
      vnoise_pkg::S_BLEND: begin
        cmd_o.op = vnoise_pkg::OP_BLEND;
        if (step_r == vnoise_pkg::BLEND_LAST) state_nxt = vnoise_pkg::S_AMP;
        else step_nxt = step_r + 1'b1;
      end
      vnoise_pkg::S_AMP: begin
        cmd_o.op  = vnoise_pkg::OP_AMP;
        state_nxt = vnoise_pkg::S_CONTRIB;
      end
      vnoise_pkg::S_CONTRIB: begin
        cmd_o.op  = vnoise_pkg::OP_CONTRIB;
        k_nxt     = k_r + 1'b1;
        state_nxt = (k_r + 1'b1 == oc) ? vnoise_pkg::S_FINISH : vnoise_pkg::S_SETUP;
      end
      vnoise_pkg::S_FINISH: begin
        if (st_i.out_free) begin
          cmd_o.op  = vnoise_pkg::OP_FINISH;
          state_nxt = vnoise_pkg::S_IDLE;
        end
      end
      default: state_nxt = vnoise_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= vnoise_pkg::S_IDLE;
      k_r      <= '0;
      step_r   <= '0;
      poly_y_r <= 1'b0;
      pt_r     <= '0;
      nbr_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      k_r      <= k_nxt;
      step_r   <= step_nxt;
      poly_y_r <= poly_y_nxt;
      pt_r     <= pt_nxt;
      nbr_r    <= nbr_nxt;
    end
  end

  // The output register must have room whenever a result is written.
  `VN_ASSERT_IMP(a_finish_room, cmd_o.op == vnoise_pkg::OP_FINISH, st_i.out_free)
  // Blending may only start once every hashed lattice point has been smoothed.
  `VN_ASSERT_IMP(a_blend_drained, state_r == vnoise_pkg::S_BLEND, !st_i.hash_busy)
  // An accepted transaction starts an octave or, with no octaves, finishes.
  `VN_ASSERT_NXT(a_accept_next, in_valid && in_ready,
                 state_r == vnoise_pkg::S_SETUP || state_r == vnoise_pkg::S_FINISH)

endmodule

/* src/value_noise_2d_octaves_core.sv */
`timescale 1ns / 1ps
// Fractal value-noise generator: one pixel coordinate in, one noise sample out.
// Input channel: in_valid/in_ready with in_x_coord and in_y_coord; a
// transaction is taken when both are high. Output channel: out_valid/out_ready
// with out_noise_value, a signed Q4.16 sample saturated to +/-8.0.
// Configuration goes through the APB port: persistence at 0x0, octave_count
// at 0x4 and table_offset at 0x8; writes are meant to happen while idle.
// Each octave runs a setup step, the shared multiplier's polynomial steps for
// the two cosine weights, the issue of 36 lattice points into the pipelined
// hash unit (one per cycle), a drain of that unit, and then the blends,
// amplitude and accumulation.
// One sample is worked on at a time. A finished sample waits in the output
// register, so the next input transaction is accepted while the receiver
// stalls; only a second finished sample waits for the register to drain.
// Synchronous reset returns the configuration to persistence 0.5, four
// octaves and table offset zero, and empties the output register.
module value_noise_2d_octaves_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [vnoise_pkg::COORD_BITS-1:0]   in_x_coord,
  input  logic [vnoise_pkg::COORD_BITS-1:0]   in_y_coord,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [vnoise_pkg::OUT_W-1:0] out_noise_value,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [vnoise_pkg::APB_AW-1:0]       paddr,
  input  logic [vnoise_pkg::APB_DW-1:0]       pwdata,
  output logic [vnoise_pkg::APB_DW-1:0]       prdata,
  output logic                                pready
);

  vnoise_pkg::cfg_t    cfg;
  vnoise_pkg::cmd_t    cmd;
  vnoise_pkg::status_t st;

  // Register file for the three configuration registers.
  vnoise_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Sequencer: walks octaves, polynomial steps, hash issue and blending.
  vnoise_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_i    (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st_i     (st),
    .cmd_o    (cmd)
  );

  // Hash pipeline, shared multiplier, accumulators and output register.
  vnoise_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_i           (cfg),
    .cmd_i           (cmd),
    .st_o            (st),
    .in_x_coord      (in_x_coord),
    .in_y_coord      (in_y_coord),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_noise_value (out_noise_value)
  );

endmodule
